@@ hdl/assert_macros.svh @@
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while in reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, switched off while in reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hdl/ipv4p_pkg.sv @@
// Package: types and constants for the dotted address parser.
package ipv4p_pkg;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0d;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_DOT   = 8'h2e;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_7     = 8'h37;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_UA    = 8'h41;
    localparam logic [7:0] CHAR_UF    = 8'h46;
    localparam logic [7:0] CHAR_UX    = 8'h58;
    localparam logic [7:0] CHAR_LA    = 8'h61;
    localparam logic [7:0] CHAR_LF    = 8'h66;
    localparam logic [7:0] CHAR_LX    = 8'h78;

    localparam logic [31:0] MAX_3BYTE = 32'h00ff_ffff;
    localparam logic [31:0] MAX_2BYTE = 32'h0000_ffff;
    localparam logic [31:0] MAX_1BYTE = 32'h0000_00ff;

    typedef enum logic [2:0] {
        MODE_NONE   = 3'd0,
        MODE_ZERO   = 3'd1,
        MODE_OCT    = 3'd2,
        MODE_HEXPFX = 3'd3,
        MODE_HEX    = 3'd4,
        MODE_DEC    = 3'd5
    } mode_t;

    typedef struct packed {
        logic       is_term;
        logic       is_dot;
        logic       is_zero;
        logic       is_x;
        logic       dec_ok;
        logic       oct_ok;
        logic       hex_ok;
        logic [3:0] digit;
    } char_class_t;

    typedef struct packed {
        logic        ok;
        logic [31:0] addr;
    } result_t;

endpackage

@@ hdl/ipv4p_char_class.sv @@
// Character decoder: terminator, dot and digit classes of one text byte.
module ipv4p_char_class (
    input  logic [7:0]                 text_char,
    output ipv4p_pkg::char_class_t     cls
);
    import ipv4p_pkg::*;

    logic is_dec;
    logic is_lhex;
    logic is_uhex;

    always_comb
    begin
        is_dec  = (text_char inside {[CHAR_0:CHAR_9]});
        is_lhex = (text_char inside {[CHAR_LA:CHAR_LF]});
        is_uhex = (text_char inside {[CHAR_UA:CHAR_UF]});

        cls.is_term = (text_char == CHAR_NUL) || (text_char == CHAR_SPACE)
                      || (text_char inside {[CHAR_TAB:CHAR_CR]});
        cls.is_dot  = (text_char == CHAR_DOT);
        cls.is_zero = (text_char == CHAR_0);
        cls.is_x    = (text_char == CHAR_LX) || (text_char == CHAR_UX);
        cls.dec_ok  = is_dec;
        cls.oct_ok  = (text_char inside {[CHAR_0:CHAR_7]});
        cls.hex_ok  = is_dec || is_lhex || is_uhex;

        if (is_dec)
        begin
            cls.digit = 4'(text_char - CHAR_0);
        end
        else if (is_lhex)
        begin
            cls.digit = 4'(text_char - CHAR_LA + 8'd10);
        end
        else
        begin
            cls.digit = 4'(text_char - CHAR_UA + 8'd10);
        end
    end

endmodule

@@ hdl/ipv4p_part_acc.sv @@
// Part accumulator: per-part value, radix mode, finished bytes and result.
module ipv4p_part_acc (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step,
    input  ipv4p_pkg::char_class_t     cls,
    output ipv4p_pkg::result_t         result
);
    import ipv4p_pkg::*;

    logic [31:0] value_reg,  value_next;
    logic        ovf_reg,    ovf_next;
    logic [7:0]  part0_reg,  part0_next;
    logic [7:0]  part1_reg,  part1_next;
    logic [7:0]  part2_reg,  part2_next;
    logic [1:0]  dots_reg,   dots_next;
    mode_t       mode_reg,   mode_next;
    logic        failed_reg, failed_next;

    logic        part_empty;
    logic [35:0] dec_sum;
    logic [31:0] oct_val;
    logic [31:0] hex_val;
    logic        dec_ovf;
    logic        oct_ovf;
    logic        hex_ovf;

    always_comb
    begin
        part_empty = (mode_reg == MODE_NONE) || (mode_reg == MODE_HEXPFX);
        dec_sum    = ({4'd0, value_reg} << 3) + ({4'd0, value_reg} << 1)
                     + {32'd0, cls.digit};
        dec_ovf    = |dec_sum[35:32];
        oct_val    = {value_reg[28:0], cls.digit[2:0]};
        oct_ovf    = |value_reg[31:29];
        hex_val    = {value_reg[27:0], cls.digit};
        hex_ovf    = |value_reg[31:28];
    end

    // Result seen when the current byte is a terminator
    always_comb
    begin
        result.ok   = !failed_reg && !part_empty && !ovf_reg;
        result.addr = value_reg;
        case (dots_reg)
            2'd0:
            begin
                result.addr = value_reg;
            end
            2'd1:
            begin
                result.ok   = result.ok && (value_reg <= MAX_3BYTE);
                result.addr = {part0_reg, 24'd0} | value_reg;
            end
            2'd2:
            begin
                result.ok   = result.ok && (value_reg <= MAX_2BYTE);
                result.addr = {part0_reg, part1_reg, 16'd0} | value_reg;
            end
            default:
            begin
                result.ok   = result.ok && (value_reg <= MAX_1BYTE);
                result.addr = {part0_reg, part1_reg, part2_reg, 8'd0} | value_reg;
            end
        endcase
        if (!result.ok)
        begin
            result.addr = '0;
        end
    end

    always_comb
    begin
        value_next  = value_reg;
        ovf_next    = ovf_reg;
        part0_next  = part0_reg;
        part1_next  = part1_reg;
        part2_next  = part2_reg;
        dots_next   = dots_reg;
        mode_next   = mode_reg;
        failed_next = failed_reg;

        if (step)
        begin
            if (cls.is_term)
            begin
                value_next  = '0;
                ovf_next    = 1'b0;
                part0_next  = '0;
                part1_next  = '0;
                part2_next  = '0;
                dots_next   = '0;
                mode_next   = MODE_NONE;
                failed_next = 1'b0;
            end
            else if (failed_reg)
            begin
                failed_next = 1'b1;
            end
            else if (cls.is_dot)
            begin
                if (part_empty || ovf_reg || (value_reg > MAX_1BYTE) || (dots_reg == 2'd3))
                begin
                    failed_next = 1'b1;
                end
                else
                begin
                    case (dots_reg)
                        2'd0:    part0_next = value_reg[7:0];
                        2'd1:    part1_next = value_reg[7:0];
                        default: part2_next = value_reg[7:0];
                    endcase
                    dots_next  = dots_reg + 2'd1;
                    value_next = '0;
                    ovf_next   = 1'b0;
                    mode_next  = MODE_NONE;
                end
            end
            else
            begin
                case (mode_reg)
                    MODE_NONE:
                    begin
                        if (cls.is_zero)
                        begin
                            mode_next = MODE_ZERO;
                        end
                        else if (cls.dec_ok)
                        begin
                            value_next = dec_sum[31:0];
                            ovf_next   = ovf_reg || dec_ovf;
                            mode_next  = MODE_DEC;
                        end
                        else
                        begin
                            failed_next = 1'b1;
                        end
                    end
                    MODE_ZERO, MODE_OCT:
                    begin
                        if ((mode_reg == MODE_ZERO) && cls.is_x)
                        begin
                            mode_next = MODE_HEXPFX;
                        end
                        else if (cls.oct_ok)
                        begin
                            value_next = oct_val;
                            ovf_next   = ovf_reg || oct_ovf;
                            mode_next  = MODE_OCT;
                        end
                        else
                        begin
                            failed_next = 1'b1;
                        end
                    end
                    MODE_HEXPFX, MODE_HEX:
                    begin
                        if (cls.hex_ok)
                        begin
                            value_next = hex_val;
                            ovf_next   = ovf_reg || hex_ovf;
                            mode_next  = MODE_HEX;
                        end
                        else
                        begin
                            failed_next = 1'b1;
                        end
                    end
                    MODE_DEC:
                    begin
                        if (cls.dec_ok)
                        begin
                            value_next = dec_sum[31:0];
                            ovf_next   = ovf_reg || dec_ovf;
                        end
                        else
                        begin
                            failed_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        failed_next = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg  <= '0;
            ovf_reg    <= 1'b0;
            part0_reg  <= '0;
            part1_reg  <= '0;
            part2_reg  <= '0;
            dots_reg   <= '0;
            mode_reg   <= MODE_NONE;
            failed_reg <= 1'b0;
        end
        else
        begin
            value_reg  <= value_next;
            ovf_reg    <= ovf_next;
            part0_reg  <= part0_next;
            part1_reg  <= part1_next;
            part2_reg  <= part2_next;
            dots_reg   <= dots_next;
            mode_reg   <= mode_next;
            failed_reg <= failed_next;
        end
    end

endmodule

@@ hdl/ipv4_dotted_address_parser.sv @@
// Top level: dotted IPv4 address text parser, one character beat per cycle unless stalled.
//
//   channel | direction | handshake         | payload
//   input   | in        | in_valid/in_stall  | text_char
//   output  | out       | out_valid/out_stall| parse_ok, address
//
// One character is taken every cycle unless in_stall is high; each character
// passes through the input register before it updates the parse state, and a
// terminator's result is then captured in the result register. Reset clears
// the parse state and both valids.
// in_stall rises only while a result waits in the output register under
// out_stall and the input register holds a terminator.
module ipv4_dotted_address_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  text_char,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        parse_ok,
    output logic [31:0] address
);
    import ipv4p_pkg::*;

    logic        s1_valid_reg, s1_valid_next;
    logic [7:0]  s1_char_reg;
    logic        out_valid_reg, out_valid_next;
    logic        ok_reg;
    logic [31:0] addr_reg;

    char_class_t cls;
    result_t     result;
    logic        blocked;
    logic        step;
    logic        res_load;

    ipv4p_char_class u_char_class (
        .text_char (s1_char_reg),
        .cls       (cls)
    );

    ipv4p_part_acc u_part_acc (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .cls    (cls),
        .result (result)
    );

    always_comb
    begin
        blocked        = cls.is_term && out_valid_reg && out_stall;
        step           = s1_valid_reg && !blocked;
        res_load       = step && cls.is_term;
        in_stall       = s1_valid_reg && blocked;
        s1_valid_next  = in_stall ? s1_valid_reg : in_valid;
        out_valid_next = res_load || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_char_reg <= text_char;
        end
        if (res_load)
        begin
            ok_reg   <= result.ok;
            addr_reg <= result.addr;
        end
    end

    assign out_valid = out_valid_reg;
    assign parse_ok  = ok_reg;
    assign address   = addr_reg;

endmodule

@@ hdl/ipv4p_checker.sv @@
// Port-level checker for the dotted address parser, bound to the top level.
`include "assert_macros.svh"

module ipv4p_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [7:0]  text_char,
    input logic        out_valid,
    input logic        out_stall,
    input logic        parse_ok,
    input logic [31:0] address
);
    import ipv4p_pkg::*;

    logic term_beat;

    assign term_beat = in_valid && !in_stall
                       && ((text_char == CHAR_NUL) || (text_char == CHAR_SPACE)
                           || ((text_char >= CHAR_TAB) && (text_char <= CHAR_CR)));

    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
                 out_valid && $stable(parse_ok) && $stable(address))
    `ASSERT_IMPL(a_fail_zero, clk, rst_n, out_valid && !parse_ok, address == 32'd0)
    `ASSERT_IMPL(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall)
    `ASSERT_IMPL(a_result_from_term, clk, rst_n, $rose(out_valid), $past(term_beat, 2))

endmodule

bind ipv4_dotted_address_parser ipv4p_checker u_ipv4p_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .text_char (text_char),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .parse_ok  (parse_ok),
    .address   (address)
);

@@ test/testbench.sv @@
// Testbench for ipv4_dotted_address_parser: random and directed address text checked beat by beat.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ipv4p_pkg::*;

    localparam int IDLE_LIMIT    = 3000;
    localparam int RANDOM_CHARS  = 1650;
    localparam int HOLD_START    = 500;
    localparam int HOLD_CYCLES   = 400;
    localparam int REPORT_LIMIT  = 10;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic [7:0]  text_char = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        parse_ok;
    logic [31:0] address;

    ipv4_dotted_address_parser i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .text_char (text_char),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .parse_ok  (parse_ok),
        .address   (address)
    );

    // text waiting to be sent and results still owed
    logic [7:0] pending_chars[$];
    logic [7:0] staged[$];
    result_t    expected_results[$];

    int  total_chars;
    int  chars_accepted = 0;
    int  mismatch_count = 0;
    bit  beat_taken     = 1'b0;
    int  send_gap       = 0;
    int  recv_gap       = 0;
    int  hold_left      = 0;
    bit  hold_done      = 1'b0;
    int  idle_cycles    = 0;

    // parser state mirror
    logic [31:0] part_acc;
    bit          part_ovf;
    logic [7:0]  finished_bytes[3];
    logic [1:0]  dot_count;
    mode_t       part_mode;
    bit          text_bad;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit is_terminator(input logic [7:0] c);
        return c == CHAR_NUL || c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

    function automatic bit is_dec(input logic [7:0] c);
        return c >= CHAR_0 && c <= CHAR_9;
    endfunction

    function automatic bit is_oct(input logic [7:0] c);
        return c >= CHAR_0 && c <= CHAR_7;
    endfunction

    function automatic int hex_value(input logic [7:0] c);
        if (is_dec(c))
            return int'(c - CHAR_0);
        if (c >= CHAR_LA && c <= CHAR_LF)
            return int'(c - CHAR_LA) + 10;
        if (c >= CHAR_UA && c <= CHAR_UF)
            return int'(c - CHAR_UA) + 10;
        return -1;
    endfunction

    function automatic bit part_missing();
        return part_mode == MODE_NONE || part_mode == MODE_HEXPFX;
    endfunction

    task automatic clear_part();
        part_acc  = '0;
        part_ovf  = 1'b0;
        part_mode = MODE_NONE;
    endtask

    task automatic clear_parse();
        clear_part();
        finished_bytes = '{8'h00, 8'h00, 8'h00};
        dot_count = 2'd0;
        text_bad  = 1'b0;
    endtask

    task automatic add_digit(input logic [4:0] radix, input logic [3:0] digit,
                             input mode_t next_mode);
        logic [35:0] wide;
        wide = {4'd0, part_acc} * radix + digit;
        if (wide[35:32] != 4'd0)
            part_ovf = 1'b1;
        part_acc  = wide[31:0];
        part_mode = next_mode;
    endtask

    task automatic parse_char(input logic [7:0] c);
        logic        ok;
        logic [31:0] addr;
        result_t     res;
        int          hv;
        hv = hex_value(c);
        if (is_terminator(c))
        begin
            ok   = !text_bad && !part_missing() && !part_ovf;
            addr = '0;
            if (ok)
            begin
                case (dot_count)
                    2'd0: addr = part_acc;
                    2'd1:
                    begin
                        ok   = part_acc <= MAX_3BYTE;
                        addr = {finished_bytes[0], 24'h0} | part_acc;
                    end
                    2'd2:
                    begin
                        ok   = part_acc <= MAX_2BYTE;
                        addr = {finished_bytes[0], finished_bytes[1], 16'h0} | part_acc;
                    end
                    default:
                    begin
                        ok   = part_acc <= MAX_1BYTE;
                        addr = {finished_bytes[0], finished_bytes[1], finished_bytes[2], 8'h0}
                               | part_acc;
                    end
                endcase
            end
            if (!ok)
                addr = '0;
            res.ok   = ok;
            res.addr = addr;
            expected_results.push_back(res);
            clear_parse();
        end
        else if (!text_bad)
        begin
            if (c == CHAR_DOT)
            begin
                if (part_missing() || part_ovf || part_acc > MAX_1BYTE || dot_count == 2'd3)
                    text_bad = 1'b1;
                else
                begin
                    finished_bytes[dot_count] = part_acc[7:0];
                    dot_count = dot_count + 2'd1;
                    clear_part();
                end
            end
            else
            begin
                case (part_mode)
                    MODE_NONE:
                        if (c == CHAR_0)
                            part_mode = MODE_ZERO;
                        else if (is_dec(c))
                            add_digit(5'd10, c[3:0], MODE_DEC);
                        else
                            text_bad = 1'b1;
                    MODE_ZERO:
                        if (c == CHAR_LX || c == CHAR_UX)
                            part_mode = MODE_HEXPFX;
                        else if (is_oct(c))
                            add_digit(5'd8, c[3:0], MODE_OCT);
                        else
                            text_bad = 1'b1;
                    MODE_OCT:
                        if (is_oct(c))
                            add_digit(5'd8, c[3:0], MODE_OCT);
                        else
                            text_bad = 1'b1;
                    MODE_HEXPFX, MODE_HEX:
                        if (hv >= 0)
                            add_digit(5'd16, hv[3:0], MODE_HEX);
                        else
                            text_bad = 1'b1;
                    MODE_DEC:
                        if (is_dec(c))
                            add_digit(5'd10, c[3:0], MODE_DEC);
                        else
                            text_bad = 1'b1;
                    default:
                        text_bad = 1'b1;
                endcase
            end
        end
    endtask

    // quiet stretches with no idling, otherwise mostly short gaps and a few long ones
    function automatic int pick_gap();
        int r;
        if ((chars_accepted / 200) % 4 == 3)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] pick_terminator();
        case ($urandom_range(0, 6))
            0: return CHAR_NUL;
            1: return CHAR_SPACE;
            default: return CHAR_TAB + 8'($urandom_range(0, 4));
        endcase
    endfunction

    function automatic int pick_radix();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return 0;
        if (r < 7)
            return 1;
        return 2;
    endfunction

    function automatic logic [7:0] digit_char(input int d);
        if (d < 10)
            return CHAR_0 + 8'(d);
        if ($urandom_range(0, 1))
            return CHAR_LA + 8'(d - 10);
        return CHAR_UA + 8'(d - 10);
    endfunction

    // radix: 0 decimal, 1 octal, 2 hex
    task automatic stage_number(input longint unsigned v, input int radix);
        logic [7:0]        digs[$];
        longint unsigned   rem;
        int                base;
        base = (radix == 0) ? 10 : (radix == 1) ? 8 : 16;
        if (radix != 0)
            staged.push_back(CHAR_0);
        if (radix == 2)
            staged.push_back($urandom_range(0, 1) ? CHAR_LX : CHAR_UX);
        if (radix != 0 && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) staged.push_back(CHAR_0);
        rem = v;
        do
        begin
            digs.push_front(digit_char(int'(rem % base)));
            rem = rem / base;
        end
        while (rem != 0);
        foreach (digs[i])
            staged.push_back(digs[i]);
    endtask

    task automatic stage_address(input int parts, input bit allow_big);
        longint unsigned v;
        longint unsigned limit;
        int              r;
        for (int i = 0; i < parts - 1; i++)
        begin
            r = $urandom_range(0, 9);
            if (allow_big && $urandom_range(0, 7) == 0)
                v = $urandom_range(256, 999);
            else if (r == 0)
                v = 0;
            else if (r == 1)
                v = 255;
            else
                v = $urandom_range(0, 255);
            stage_number(v, pick_radix());
            staged.push_back(CHAR_DOT);
        end
        limit = 64'hffff_ffff >> (8 * (parts - 1));
        r = $urandom_range(0, 9);
        case (r)
            0: v = limit;
            1: v = 0;
            2: v = allow_big ? limit + 1 + $urandom_range(0, 3) : limit;
            3: v = $urandom_range(0, 255) & limit;
            default: v = longint'($urandom) & limit;
        endcase
        stage_number(v, pick_radix());
    endtask

    task automatic flush_string();
        staged.push_back(pick_terminator());
        foreach (staged[i])
            pending_chars.push_back(staged[i]);
        staged.delete();
    endtask

    task automatic queue_text(input string s, input logic [7:0] term);
        for (int i = 0; i < s.len(); i++)
            pending_chars.push_back(s[i]);
        pending_chars.push_back(term);
    endtask

    task automatic stage_broken();
        int idx;
        case ($urandom_range(0, 9))
            0: ;
            1:
            begin
                stage_address($urandom_range(1, 3), 1'b0);
                idx = $urandom_range(0, 2);
                if (idx == 0)
                    staged.push_front(CHAR_DOT);
                else if (idx == 1)
                    staged.push_back(CHAR_DOT);
                else
                begin
                    staged.push_back(CHAR_DOT);
                    staged.push_back(CHAR_DOT);
                    stage_number($urandom_range(0, 255), 0);
                end
            end
            2, 3:
            begin
                stage_address($urandom_range(1, 4), 1'b0);
                idx = $urandom_range(0, staged.size() - 1);
                case ($urandom_range(0, 2))
                    0: staged[idx] = 8'($urandom);
                    1: staged.insert(idx, 8'($urandom_range(128, 255)));
                    default: staged.delete(idx);
                endcase
            end
            4:
            begin
                stage_address(4, 1'b0);
                repeat ($urandom_range(1, 2))
                begin
                    staged.push_back(CHAR_DOT);
                    stage_number($urandom_range(0, 255), pick_radix());
                end
            end
            5:
            begin
                if ($urandom_range(0, 1))
                begin
                    stage_address($urandom_range(1, 3), 1'b0);
                    staged.push_back(CHAR_DOT);
                end
                stage_number(64'h1_0000_0000 + $urandom, pick_radix());
            end
            6:
            begin
                staged.push_back(CHAR_0);
                staged.push_back($urandom_range(0, 1) ? CHAR_LX : CHAR_UX);
                if ($urandom_range(0, 1))
                begin
                    staged.push_back(CHAR_DOT);
                    stage_number($urandom_range(0, 255), 0);
                end
            end
            7:
            begin
                staged.push_back(CHAR_0);
                repeat ($urandom_range(0, 3)) staged.push_back(CHAR_0 + 8'($urandom_range(0, 7)));
                staged.push_back(CHAR_0 + 8'($urandom_range(8, 9)));
            end
            default:
                repeat ($urandom_range(1, 12)) staged.push_back(8'($urandom));
        endcase
    endtask

    initial
    begin
        clear_parse();
        queue_text("", CHAR_NUL);
        queue_text("0xFFFFFFFF", CHAR_SPACE);
        queue_text("1.2.3.4.5", 8'h0a);
        queue_text("08", CHAR_CR);
        while (pending_chars.size() < RANDOM_CHARS + 25)
        begin
            if ($urandom_range(0, 3) != 0)
                stage_address($urandom_range(1, 4), $urandom_range(0, 5) == 0);
            else
                stage_broken();
            flush_string();
        end
        total_chars = pending_chars.size();

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (chars_accepted < total_chars)
            @(negedge clk);
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);

        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // sender
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || beat_taken))
        begin
            if (send_gap > 0)
            begin
                send_gap = send_gap - 1;
                in_valid <= 1'b0;
            end
            else if (pending_chars.size() > 0)
            begin
                text_char <= pending_chars.pop_front();
                in_valid  <= 1'b1;
                send_gap = pick_gap();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver, with one long hold-off to fill the block
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                out_stall <= 1'b1;
            end
            else if (!hold_done && chars_accepted >= HOLD_START)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                out_stall <= 1'b1;
            end
            else if (recv_gap > 0)
            begin
                recv_gap = recv_gap - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
                recv_gap = pick_gap();
            end
        end
    end

    // input beats feed the predictor
    always @(posedge clk)
    begin
        beat_taken <= rst_n && in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
        begin
            parse_char(text_char);
            chars_accepted <= chars_accepted + 1;
        end
    end

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                mismatch_count = mismatch_count + 1;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected result beat: ok=%0d addr=%08h", parse_ok, address);
            end
            else
            begin
                want = expected_results.pop_front();
                if (parse_ok !== want.ok || address !== want.addr)
                begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("result mismatch: expected ok=%0d addr=%08h, got ok=%0d addr=%08h",
                                 want.ok, want.addr, parse_ok, address);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

endmodule
